// ===== rtl/core/thermc_pkg.sv =====
// shared types and constants for the thermistor / infrared temperature conditioner
// no dependencies; imported by every module of the block except thermc_div

package thermc_pkg;

  localparam int unsigned ADC_FULL_SCALE_DEF  = 1023;
  localparam int unsigned ADC_INVERT_MASK_DEF = 0;
  localparam int unsigned OPEN_MARGIN         = 10;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned LOG_IN_W   = 36;
  localparam int unsigned LOG_FRAC_W = 24;
  localparam int unsigned LOG_EXP_W  = 6;
  localparam int unsigned LOG_OUT_W  = LOG_EXP_W + LOG_FRAC_W;

  localparam int unsigned BDIV_NUM_W = 64;
  localparam int unsigned BDIV_DEN_W = 50;
  localparam int unsigned SDIV_NUM_W = 20;
  localparam int unsigned SDIV_DEN_W = 4;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic signed [19:0] ABS_ZERO_C = 20'sd27315;
  localparam logic signed [19:0] IR_OFFSET  = 20'sd27316;
  localparam logic signed [19:0] OUT_MIN    = -20'sd27400;
  localparam logic signed [19:0] HOT_LIMIT  = 20'sd50000;
  localparam logic signed [22:0] SMOOTH_BIAS = 23'sd274005;
  localparam logic [SDIV_DEN_W-1:0] SMOOTH_DIV = 4'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SENSOR_ENABLE = 3'd0,
    REG_SENSOR_KIND   = 3'd1,
    REG_REFRESH_TICKS = 3'd2,
    REG_START_OFFSET  = 3'd3,
    REG_BETA_COEFF    = 3'd4,
    REG_NOMINAL_RES   = 3'd5,
    REG_SERIES_RES    = 3'd6,
    REG_NOMINAL_TEMP  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [9:0] adc_sample;
    logic [7:0] ir_low;
    logic [7:0] ir_high;
    logic       ir_addr_error;
    logic       ir_timeout;
  } in_t;

  typedef struct packed {
    logic signed [16:0] temperature;
    logic               failure;
  } out_t;

endpackage

// ===== rtl/core/thermistor_ir_temperature_conditioner_top.sv =====
// thermistor / infrared temperature conditioner, top level with sequencer
// depends on thermc_pkg, thermc_log2, thermc_div
//
// usage
//   in_*  : one beat per tick, carrying the adc sample and the ir reply bytes
//   out_* : at most one beat per tick, the smoothed temperature in 0.01 C and failure
//   cfg_* : plain register writes, index per cfg_reg_t; the user writes only while idle, the block does not enforce it
// a tick is consumed only while the sequencer is idle (in_ready high); ticks that
// do not hit the end of the countdown are absorbed without leaving idle
// work of a measuring tick
//   ir mode  : mainly the serial divide by ten of the smoother
//   ntc mode : two log2 passes (a normalize, then 24 squarings each) and a
//              64-bit bit-serial quotient dominate
// one measurement is in flight at a time; the next tick is taken as soon as the
// result sits in the output register, even if the receiver has not taken it yet
// receiver stall: a finished result waits in the output register; a second result
// waits in the sequencer until that register frees up
// reset: registers return to defaults, countdown zero (inactive), smoother zero,
// failure cleared, output empty

module thermistor_ir_temperature_conditioner_top #(
  parameter int unsigned ADC_FULL_SCALE  = thermc_pkg::ADC_FULL_SCALE_DEF,
  parameter int unsigned ADC_INVERT_MASK = thermc_pkg::ADC_INVERT_MASK_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  thermc_pkg::in_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output thermc_pkg::out_t                  out_data,
  input  logic                              cfg_we,
  input  logic [thermc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [thermc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import thermc_pkg::*;

  localparam logic [15:0] FS       = 16'(ADC_FULL_SCALE);
  localparam logic [9:0]  IMASK    = 10'(ADC_INVERT_MASK);
  localparam logic [16:0] OPEN_LIM = 17'(ADC_FULL_SCALE - OPEN_MARGIN);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_LOGN, S_LOGN_W, S_LOGD, S_LOGD_W, S_LN2, S_PROD, S_SUM,
    S_DIVSET, S_DIV, S_DIV_W, S_POST, S_SMOOTH, S_SMOOTH_GO, S_SMOOTH_W, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic               en_r, kind_r;
  logic [15:0]        refresh_r;
  logic [7:0]         offset_r;
  logic [13:0]        beta_r;
  logic [19:0]        r0_r, rs_r;
  logic signed [15:0] t0c_r;

  // block state
  logic [16:0]        cd_r;
  logic signed [19:0] sm_r;
  logic               fail_r;

  // measurement datapath
  logic [9:0]              a_r;
  logic [LOG_IN_W-1:0]     num_r, den_r;
  logic [LOG_OUT_W-1:0]    ln_r, ld_r;
  logic signed [30:0]      lq_r;
  logic [20:0]             bq_r;
  logic signed [38:0]      nnc_r;
  logic signed [48:0]      t0lq_r;
  logic signed [49:0]      dd_r;
  logic [BDIV_NUM_W-1:0]   dnum_r;
  logic [BDIV_DEN_W-1:0]   dden_r;
  logic                    neg_r;
  logic signed [19:0]      x_r;
  logic [SDIV_NUM_W-1:0]   snum_r;
  logic                    out_valid_r;
  out_t                    out_data_r;

  // combinational helpers
  logic [15:0]          eff;
  logic [16:0]          cd_dec;
  logic [9:0]           a_in;
  logic                 open_in;
  logic signed [19:0]   x_ir;
  logic [29:0]          num_p;
  logic [35:0]          den_p;
  logic signed [30:0]   dlog;
  logic [29:0]          dmag;
  logic [59:0]          lnp;
  logic [29:0]          lqmag;
  logic signed [30:0]   lq_c;
  logic signed [17:0]   t0;
  logic [38:0]          nabs;
  logic [49:0]          dabs;
  logic [16:0]          qs;
  logic signed [19:0]   qext, tq, tpost;
  logic signed [22:0]   sacc;

  logic                  log_start, log_done;
  logic [LOG_IN_W-1:0]   log_in;
  logic [LOG_OUT_W-1:0]  log_res;
  logic                  bdiv_start, bdiv_done;
  logic [BDIV_NUM_W-1:0] bdiv_q;
  logic                  sdiv_start, sdiv_done;
  logic [SDIV_NUM_W-1:0] sdiv_q;

  assign eff     = (refresh_r == 16'd0) ? 16'd1 : refresh_r;
  assign cd_dec  = cd_r - 17'd1;
  assign a_in    = in_data.adc_sample ^ IMASK;
  assign open_in = {7'b0, a_in} >= OPEN_LIM;
  // ir: raw*0.02 K -> raw*2 centikelvin, error bit of the high byte dropped
  assign x_ir    = $signed({4'b0, in_data.ir_high[6:0], in_data.ir_low, 1'b0}) - IR_OFFSET;

  // divider resistances, ratio r/r0 = num/den
  assign num_p = 30'(rs_r) * 30'(a_r);
  assign den_p = 36'(FS - 16'(a_r)) * 36'(r0_r);

  // ln(r/r0) = (log2 num - log2 den) * ln2, rounded to q24
  assign dlog  = $signed({1'b0, ln_r}) - $signed({1'b0, ld_r});
  assign dmag  = dlog[30] ? 30'(-dlog) : dlog[29:0];
  assign lnp   = 60'(dmag) * 60'(LN2_Q30) + (60'(1) << 29);
  assign lqmag = lnp[59:30];
  assign lq_c  = dlog[30] ? -$signed({1'b0, lqmag}) : $signed({1'b0, lqmag});

  // nominal temperature in centikelvin
  assign t0 = 18'(t0c_r) + 18'(ABS_ZERO_C);

  assign nabs = nnc_r[38] ? 39'(-nnc_r) : 39'(nnc_r);
  assign dabs = dd_r[49] ? 50'(-dd_r) : 50'(dd_r);

  // quotient saturated well past the hot and cold limits
  assign qs    = (|bdiv_q[BDIV_NUM_W-1:17]) ? '1 : bdiv_q[16:0];
  assign qext  = $signed({3'b0, qs});
  assign tq    = neg_r ? (-qext - ABS_ZERO_C) : (qext - ABS_ZERO_C);
  assign tpost = (!neg_r && tq > HOT_LIMIT) ? 20'sd0 :
                 (tq < OUT_MIN) ? OUT_MIN : tq;

  // smoother numerator 7*s + 3*x - 10*min + 5, always positive
  assign sacc = 23'(sm_r) * 23'sd7 + 23'(x_r) * 23'sd3 + SMOOTH_BIAS;

  assign log_start  = ((state_r == S_LOGN) && (num_r != '0) && (den_r != '0)) ||
                      (state_r == S_LOGD);
  assign log_in     = (state_r == S_LOGD) ? den_r : num_r;
  assign bdiv_start = (state_r == S_DIV);
  assign sdiv_start = (state_r == S_SMOOTH_GO);

  thermc_log2 u_log2 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (log_start),
    .n     (log_in),
    .done  (log_done),
    .res   (log_res)
  );

  thermc_div #(.NW(BDIV_NUM_W), .DW(BDIV_DEN_W)) u_bdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (bdiv_start),
    .num   (dnum_r),
    .den   (dden_r),
    .done  (bdiv_done),
    .quot  (bdiv_q)
  );

  thermc_div #(.NW(SDIV_NUM_W), .DW(SDIV_DEN_W)) u_sdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sdiv_start),
    .num   (snum_r),
    .den   (SMOOTH_DIV),
    .done  (sdiv_done),
    .quot  (sdiv_q)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      en_r        <= 1'b0;
      kind_r      <= 1'b0;
      refresh_r   <= 16'd100;
      offset_r    <= 8'd0;
      beta_r      <= 14'd3950;
      r0_r        <= 20'd10000;
      rs_r        <= 20'd1000;
      t0c_r       <= 16'sd2600;
      cd_r        <= '0;
      sm_r        <= '0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && cd_r != '0) begin
            if (cd_dec != '0) begin
              cd_r <= cd_dec;
            end else begin
              cd_r <= 17'(eff);
              if (!kind_r) begin
                if (open_in) begin
                  fail_r  <= 1'b1;
                  x_r     <= '0;
                  state_r <= S_SMOOTH;
                end else begin
                  a_r     <= a_in;
                  state_r <= S_MUL;
                end
              end else if (in_data.ir_timeout) begin
                // bus timeout: flag only, no beat
                fail_r <= 1'b1;
              end else begin
                fail_r  <= in_data.ir_addr_error;
                x_r     <= x_ir;
                state_r <= S_SMOOTH;
              end
            end
          end
        end
        S_MUL: begin
          num_r   <= 36'(num_p);
          den_r   <= den_p;
          state_r <= S_LOGN;
        end
        S_LOGN: begin
          if (num_r == '0 || den_r == '0) begin
            x_r     <= -ABS_ZERO_C;
            state_r <= S_SMOOTH;
          end else begin
            state_r <= S_LOGN_W;
          end
        end
        S_LOGN_W: begin
          if (log_done) begin
            ln_r    <= log_res;
            state_r <= S_LOGD;
          end
        end
        S_LOGD: state_r <= S_LOGD_W;
        S_LOGD_W: begin
          if (log_done) begin
            ld_r    <= log_res;
            state_r <= S_LN2;
          end
        end
        S_LN2: begin
          lq_r    <= lq_c;
          bq_r    <= 21'(beta_r) * 21'd100;
          state_r <= S_PROD;
        end
        S_PROD: begin
          nnc_r   <= 39'(t0) * 39'($signed({1'b0, bq_r}));
          t0lq_r  <= 49'(t0) * 49'(lq_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          dd_r    <= 50'(t0lq_r) + 50'({bq_r, 24'b0});
          state_r <= S_DIVSET;
        end
        S_DIVSET: begin
          if (dd_r == '0) begin
            x_r     <= '0;
            state_r <= S_SMOOTH;
          end else begin
            // round half away: (2^25 |n| + |d|) / (2|d|)
            dnum_r  <= {nabs, 25'b0} + 64'(dabs);
            dden_r  <= {dabs[48:0], 1'b0};
            neg_r   <= nnc_r[38] ^ dd_r[49];
            state_r <= S_DIV;
          end
        end
        S_DIV: state_r <= S_DIV_W;
        S_DIV_W: begin
          if (bdiv_done) begin
            state_r <= S_POST;
          end
        end
        S_POST: begin
          x_r     <= tpost;
          state_r <= S_SMOOTH;
        end
        S_SMOOTH: begin
          snum_r  <= sacc[SDIV_NUM_W-1:0];
          state_r <= S_SMOOTH_GO;
        end
        S_SMOOTH_GO: state_r <= S_SMOOTH_W;
        S_SMOOTH_W: begin
          if (sdiv_done) begin
            sm_r    <= $signed(sdiv_q) + OUT_MIN;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r            <= 1'b1;
            out_data_r.temperature <= sm_r[16:0];
            out_data_r.failure     <= fail_r;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // register writes: the user issues them only while idle; the block does not enforce it
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_addr))
          REG_SENSOR_ENABLE: begin
            en_r <= cfg_wdata[0];
            cd_r <= cfg_wdata[0] ? (17'(eff) + 17'(offset_r)) : '0;
          end
          REG_SENSOR_KIND:   kind_r    <= cfg_wdata[0];
          REG_REFRESH_TICKS: refresh_r <= cfg_wdata[15:0];
          REG_START_OFFSET:  offset_r  <= cfg_wdata[7:0];
          REG_BETA_COEFF:    beta_r    <= cfg_wdata[13:0];
          REG_NOMINAL_RES:   r0_r      <= cfg_wdata[19:0];
          REG_SERIES_RES:    rs_r      <= cfg_wdata[19:0];
          REG_NOMINAL_TEMP:  t0c_r     <= $signed(cfg_wdata[15:0]);
          default: ;
        endcase
      end
    end
  end

  // sensor_enable is kept as state; the countdown carries its effect
  logic unused_en;
  assign unused_en = en_r;

endmodule

// ===== rtl/core/thermc_log2.sv =====
// base-2 logarithm in Q24: one-bit-per-cycle normalize, then one squaring per cycle
// depends on thermc_pkg

module thermc_log2 (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [thermc_pkg::LOG_IN_W-1:0] n,
  output logic                            done,
  output logic [thermc_pkg::LOG_OUT_W-1:0] res
);
  import thermc_pkg::*;

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} phase_t;

  phase_t                  phase_r;
  logic [LOG_IN_W-1:0]     sh_r;
  logic [LOG_EXP_W-1:0]    sc_r;
  logic [30:0]             m_r;
  logic [LOG_FRAC_W-1:0]   f_r;
  logic [4:0]              it_r;
  logic                    done_r;
  logic [61:0]             sq;
  logic [31:0]             top;
  logic [LOG_EXP_W-1:0]    e;

  assign sq   = 62'(m_r) * 62'(m_r);
  assign top  = sq[61:30];
  assign e    = LOG_EXP_W'(LOG_IN_W - 1) - sc_r;
  assign res  = {e, f_r};
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        L_IDLE: begin
          if (start) begin
            sh_r    <= n;
            sc_r    <= '0;
            phase_r <= L_NORM;
          end
        end
        L_NORM: begin
          if (sh_r[LOG_IN_W-1]) begin
            m_r     <= sh_r[LOG_IN_W-1 -: 31];
            f_r     <= '0;
            it_r    <= '0;
            phase_r <= L_SQ;
          end else begin
            sh_r <= sh_r << 1;
            sc_r <= sc_r + 1'b1;
          end
        end
        L_SQ: begin
          if (top[31]) begin
            m_r <= top[31:1];
            f_r <= {f_r[LOG_FRAC_W-2:0], 1'b1};
          end else begin
            m_r <= top[30:0];
            f_r <= {f_r[LOG_FRAC_W-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (it_r == 5'(LOG_FRAC_W - 1)) begin
            phase_r <= L_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: phase_r <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/thermc_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on nothing but its parameters

module thermc_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 50
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (start) begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          q_r    <= num;
          rem_r  <= '0;
          den_r  <= den;
        end
      end else begin
        rem_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        q_r   <= {q_r[NW-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/thermc_chk.sv =====
// port-level checks for the temperature conditioner, bound to the top level
// depends on thermc_pkg and thermistor_ir_temperature_conditioner_top

module thermc_chk (
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input thermc_pkg::out_t out_data
);
  import thermc_pkg::*;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present right after reset");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.temperature) >= -17'sd27400 &&
                   $signed(out_data.temperature) <= 17'sd50000))
    else $error("smoothed temperature out of range");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("output beat changed while stalled");

endmodule

bind thermistor_ir_temperature_conditioner_top thermc_chk u_thermc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
